### design/chs_pkg.sv
// Shared types, constants and ordering functions for the convex hull block.
`timescale 1ns / 1ps
package chs_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int Q_DEPTH = 4;

  typedef struct packed {
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        set_end;
  } in_word_t;

  typedef struct packed {
    logic [15:0] vertex_x;
    logic [15:0] vertex_y;
    logic        run_end;
    logic        overflowed;
  } out_word_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } point_t;

  // Classified word handed from front to back.
  typedef struct packed {
    point_t pt;
    logic   keep;
    logic   last;
    logic   ovf;
  } q_word_t;

  typedef struct packed {
    logic    valid;
    q_word_t word;
  } q_link_t;

  // Load order: x descending, ties y ascending.
  function automatic logic load_before(point_t a, point_t b);
    return (a.x > b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

  // Output order: y per mode, ties x ascending.
  function automatic logic out_before(point_t a, point_t b, logic mode);
    if (a.y != b.y) begin
      return mode ? (a.y > b.y) : (a.y < b.y);
    end
    return a.x < b.x;
  endfunction

endpackage

### design/chs_ram.sv
// Generic one-write one-read RAM with registered read data.
`timescale 1ns / 1ps
module chs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/chs_front.sv
// Front end: accepts points, applies the capacity check and queues words.
`timescale 1ns / 1ps
module chs_front #(
  parameter int MAX_POINTS = chs_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  chs_pkg::in_word_t  pt_in,
  output chs_pkg::q_link_t   link,
  input  logic               link_pop
);
  import chs_pkg::*;

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int QAW = $clog2(Q_DEPTH);
  localparam int QCW = $clog2(Q_DEPTH + 1);

  q_word_t        q_mem [Q_DEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QCW-1:0] qcnt;
  logic [CW-1:0]  fcnt;
  logic           fovf;

  logic    accept;
  logic    keep;
  logic    ovf_set;
  q_word_t word_in;

  assign full    = (qcnt == QCW'(Q_DEPTH));
  assign accept  = push && !full;
  assign keep    = (fcnt < CW'(MAX_POINTS));
  assign ovf_set = fovf | ~keep;

  always_comb begin
    word_in.pt.x = pt_in.point_x;
    word_in.pt.y = pt_in.point_y;
    word_in.keep = keep;
    word_in.last = pt_in.set_end;
    word_in.ovf  = ovf_set;
  end

  assign link.valid = (qcnt != '0);
  assign link.word  = q_mem[rptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem[wptr] <= word_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      qcnt <= '0;
      fcnt <= '0;
      fovf <= 1'b0;
    end else begin
      if (accept) begin
        wptr <= wptr + QAW'(1);
        if (pt_in.set_end) begin
          fcnt <= '0;
          fovf <= 1'b0;
        end else begin
          fcnt <= fcnt + CW'(keep);
          fovf <= ovf_set;
        end
      end
      if (link_pop) begin
        rptr <= rptr + QAW'(1);
      end
      qcnt <= qcnt + QCW'(accept) - QCW'(link_pop);
    end
  end

endmodule

### design/chs_back.sv
// Back end: sorted point store, monotone chain passes and ordered vertex output.
`timescale 1ns / 1ps
module chs_back #(
  parameter int MAX_POINTS = chs_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  chs_pkg::q_link_t   link,
  output logic               link_pop,
  input  logic               order_mode,
  output logic               empty,
  input  logic               pop,
  output chs_pkg::out_word_t vtx_out
);
  import chs_pkg::*;

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int PW  = $clog2(MAX_POINTS);
  localparam int SD  = MAX_POINTS + 2;
  localparam int SAW = $clog2(SD);
  localparam int HW  = $clog2(SD + 1);

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_INS_RD  = 14'b00000000000010,
    ST_INS_CMP = 14'b00000000000100,
    ST_FETCH   = 14'b00000000001000,
    ST_GETB    = 14'b00000000010000,
    ST_CHK     = 14'b00000000100000,
    ST_MUL     = 14'b00000001000000,
    ST_DEC     = 14'b00000010000000,
    ST_POPW    = 14'b00000100000000,
    ST_PUSH    = 14'b00001000000000,
    ST_SRD     = 14'b00010000000000,
    ST_SCMP    = 14'b00100000000000,
    ST_SWAP    = 14'b01000000000000,
    ST_EMIT    = 14'b10000000000000
  } state_t;

  state_t        state;
  logic [CW-1:0] npts;
  logic [CW-1:0] j;
  logic [CW-1:0] i;
  point_t        key;
  logic          last_r;
  logic          ovf_r;
  logic          pass;
  logic [HW-1:0] hcnt;
  logic [HW-1:0] low;
  point_t        a_pt;
  point_t        o_pt;
  point_t        b_pt;
  logic signed [33:0] p1;
  logic signed [33:0] p2;
  logic [HW-1:0]  k;
  logic [HW-1:0]  sj;
  point_t         best;
  logic [SAW-1:0] bidx;
  point_t         savek;
  logic           out_valid;
  out_word_t      out_word;

  logic           p_we;
  logic [PW-1:0]  p_waddr;
  logic [31:0]    p_wdata;
  logic [PW-1:0]  p_raddr;
  logic [31:0]    p_rdata;
  logic           s_we;
  logic [SAW-1:0] s_waddr;
  logic [31:0]    s_wdata;
  logic [SAW-1:0] s_raddr;
  logic [31:0]    s_rdata;

  point_t        p_rd;
  point_t        s_rd;
  logic [CW-1:0] j_m1;
  logic [CW-1:0] i_m1;
  logic [HW-1:0] hm1;
  logic [HW-1:0] hm3;
  logic          turn_le;
  logic signed [16:0] dx1, dy1, dx2, dy2;

  assign p_rd    = point_t'(p_rdata);
  assign s_rd    = point_t'(s_rdata);
  assign j_m1    = j - CW'(1);
  assign i_m1    = i - CW'(1);
  assign hm1     = hcnt - HW'(1);
  assign hm3     = hcnt - HW'(3);
  assign turn_le = (p1 <= p2);

  assign dx1 = $signed({1'b0, a_pt.x}) - $signed({1'b0, o_pt.x});
  assign dy1 = $signed({1'b0, a_pt.y}) - $signed({1'b0, o_pt.y});
  assign dx2 = $signed({1'b0, b_pt.x}) - $signed({1'b0, o_pt.x});
  assign dy2 = $signed({1'b0, b_pt.y}) - $signed({1'b0, o_pt.y});

  assign link_pop = (state == ST_IDLE) && link.valid;
  assign empty    = !out_valid;
  assign vtx_out  = out_word;

  always_comb begin
    p_we    = 1'b0;
    p_waddr = j[PW-1:0];
    p_wdata = key;
    p_raddr = j_m1[PW-1:0];
    s_we    = 1'b0;
    s_waddr = hcnt[SAW-1:0];
    s_wdata = b_pt;
    s_raddr = hm3[SAW-1:0];
    unique case (state)
      ST_INS_RD: begin
        p_we = (j == '0);
      end
      ST_INS_CMP: begin
        p_we    = 1'b1;
        p_wdata = load_before(key, p_rd) ? p_rd : key;
      end
      ST_FETCH: begin
        p_raddr = pass ? i_m1[PW-1:0] : i[PW-1:0];
      end
      ST_PUSH: begin
        s_we = 1'b1;
      end
      ST_SRD: begin
        s_raddr = sj[SAW-1:0];
      end
      ST_SWAP: begin
        s_we    = 1'b1;
        s_waddr = bidx;
        s_wdata = savek;
      end
      default: ;
    endcase
  end

  chs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_pts (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  chs_ram #(.WIDTH(32), .DEPTH(SD)) u_stk (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      npts      <= '0;
      hcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      // output register: load a new word in EMIT, else drop the taken one
      if ((state == ST_EMIT) && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (link.valid) begin
            last_r <= link.word.last;
            ovf_r  <= link.word.ovf;
            key    <= link.word.pt;
            j      <= npts;
            if (link.word.keep) begin
              state <= ST_INS_RD;
            end else if (link.word.last) begin
              hcnt  <= '0;
              i     <= '0;
              pass  <= 1'b0;
              state <= ST_FETCH;
            end
          end
        end
        ST_INS_RD: begin
          if (j == '0) begin
            npts <= npts + CW'(1);
            if (last_r) begin
              hcnt  <= '0;
              i     <= '0;
              pass  <= 1'b0;
              state <= ST_FETCH;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_INS_CMP;
          end
        end
        ST_INS_CMP: begin
          if (load_before(key, p_rd)) begin
            j     <= j_m1;
            state <= ST_INS_RD;
          end else begin
            npts <= npts + CW'(1);
            if (last_r) begin
              hcnt  <= '0;
              i     <= '0;
              pass  <= 1'b0;
              state <= ST_FETCH;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_GETB;
        end
        ST_GETB: begin
          b_pt  <= p_rd;
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (pass ? (hcnt > low) : (hcnt >= HW'(2))) begin
            state <= ST_MUL;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_MUL: begin
          p1    <= dx1 * dy2;
          p2    <= dy1 * dx2;
          state <= ST_DEC;
        end
        ST_DEC: begin
          if (turn_le) begin
            hcnt <= hm1;
            a_pt <= o_pt;
            state <= (hm1 >= HW'(2)) ? ST_POPW : ST_CHK;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_POPW: begin
          o_pt  <= s_rd;
          state <= ST_CHK;
        end
        ST_PUSH: begin
          o_pt <= a_pt;
          a_pt <= b_pt;
          if (!pass) begin
            hcnt  <= hcnt + HW'(1);
            state <= ST_FETCH;
            if (i == npts - CW'(1)) begin
              pass <= 1'b1;
              low  <= hcnt + HW'(1);
              i    <= npts;
            end else begin
              i <= i + CW'(1);
            end
          end else if (i == CW'(1)) begin
            // closing vertex repeats the first one: push and drop cancel
            k     <= '0;
            sj    <= '0;
            state <= ST_SRD;
          end else begin
            hcnt  <= hcnt + HW'(1);
            i     <= i_m1;
            state <= ST_FETCH;
          end
        end
        ST_SRD: begin
          state <= ST_SCMP;
        end
        ST_SCMP: begin
          if ((sj == k) || out_before(s_rd, best, order_mode)) begin
            best <= s_rd;
            bidx <= sj[SAW-1:0];
          end
          if (sj == k) begin
            savek <= s_rd;
          end
          if (sj + HW'(1) == hcnt) begin
            state <= ST_SWAP;
          end else begin
            sj    <= sj + HW'(1);
            state <= ST_SRD;
          end
        end
        ST_SWAP: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || pop) begin
            out_word.vertex_x   <= best.x;
            out_word.vertex_y   <= best.y;
            out_word.run_end    <= (k + HW'(1) == hcnt);
            out_word.overflowed <= ovf_r;
            if (k + HW'(1) == hcnt) begin
              npts  <= '0;
              state <= ST_IDLE;
            end else begin
              k     <= k + HW'(1);
              sj    <= k + HW'(1);
              state <= ST_SRD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    hcnt <= HW'(SD)) else $error("hull stack beyond depth");
  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    npts <= CW'(MAX_POINTS)) else $error("point store beyond capacity");
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCMP) |-> (sj < hcnt)) else $error("scan past hull");
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !out_valid) |=> out_valid) else $error("vertex not emitted");
`endif

endmodule

### design/convex_hull_sorted_output.sv
// Top level: convex hull of a point set, vertices emitted in y order.
// Flow: a point word enters a 4-word queue (one push per cycle while not full).
// Back end inserts each kept point into the sorted store, moving entries until it lands in place or at the front.
// Hull passes use one shared two-product turn unit.
// Output picks each vertex with a selection scan over the stack RAM port.
// Reset (rst, synchronous): queue, counters, order_mode and output valid clear; RAMs do not.
`timescale 1ns / 1ps
module convex_hull_sorted_output #(
  parameter int MAX_POINTS = chs_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  chs_pkg::in_word_t  pt_in,
  output logic               empty,
  input  logic               pop,
  output chs_pkg::out_word_t vtx_out,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import chs_pkg::*;

  q_link_t link;
  logic    link_pop;
  logic    order_mode;  // 0: y ascending, 1: y descending

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
    end else if (cfg_we) begin
      order_mode <= cfg_wdata;
    end
  end

  // front: capacity check and overflow marking per set, then the queue
  chs_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .pt_in    (pt_in),
    .link     (link),
    .link_pop (link_pop)
  );

  // back: sorted store, chain passes, ordered output word register
  chs_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .link       (link),
    .link_pop   (link_pop),
    .order_mode (order_mode),
    .empty      (empty),
    .pop        (pop),
    .vtx_out    (vtx_out)
  );

endmodule

### bench/convex_hull_sorted_output_tb.sv
// Testbench for convex_hull_sorted_output: random point sets checked against a hull predictor.
`timescale 1ns / 1ps
module convex_hull_sorted_output_tb;
  import chs_pkg::*;

  localparam int CAPACITY = MAX_POINTS_DEF;
  localparam int SETTLE = 400;

  // Predicts the hull vertices of each point set and holds them until they come out.
  class hull_scoreboard;
    point_t    pts[$];
    bit        ovf;
    bit        mode;
    out_word_t hull_q[$];
    int        errors;

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function bit goes_first(point_t a, point_t b, bit for_out);
      if (!for_out) return (a.x > b.x) || (a.x == b.x && a.y < b.y);
      if (a.y != b.y) return mode ? (a.y > b.y) : (a.y < b.y);
      return a.x < b.x;
    endfunction

    function void order(ref point_t v[$], input bit for_out);
      point_t key;
      int j;
      for (int i = 1; i < v.size(); i++) begin
        key = v[i];
        j = i;
        while (j > 0 && goes_first(key, v[j-1], for_out)) begin
          v[j] = v[j-1];
          j--;
        end
        v[j] = key;
      end
    endfunction

    function longint turn(point_t o, point_t a, point_t b);
      longint ax, ay, bx, by;
      ax = longint'(a.x) - longint'(o.x);
      ay = longint'(a.y) - longint'(o.y);
      bx = longint'(b.x) - longint'(o.x);
      by = longint'(b.y) - longint'(o.y);
      return ax * by - ay * bx;
    endfunction

    function void build_hull();
      int stk[2*CAPACITY+2];
      int h, low, n;
      point_t verts[$];
      out_word_t w;
      order(pts, 0);
      n = pts.size();
      h = 0;
      for (int i = 0; i < n; i++) begin
        while (h >= 2 && turn(pts[stk[h-2]], pts[stk[h-1]], pts[i]) <= 0) h--;
        stk[h++] = i;
      end
      low = h;
      for (int i = n; i > 0; i--) begin
        while (h > low && turn(pts[stk[h-2]], pts[stk[h-1]], pts[i-1]) <= 0) h--;
        stk[h++] = i - 1;
      end
      if (h > 0) h--;   // closing vertex repeats the first
      for (int k = 0; k < h; k++) verts.push_back(pts[stk[k]]);
      order(verts, 1);
      for (int k = 0; k < h; k++) begin
        w.vertex_x = verts[k].x;
        w.vertex_y = verts[k].y;
        w.run_end = (k + 1 == h);
        w.overflowed = ovf;
        hull_q.push_back(w);
      end
      pts.delete();
      ovf = 0;
    endfunction

    function void note_point(in_word_t w);
      point_t p;
      p.x = w.point_x;
      p.y = w.point_y;
      if (pts.size() < CAPACITY) pts.push_back(p);
      else ovf = 1;
      if (w.set_end) build_hull();
    endfunction

    task check_vertex(out_word_t got);
      out_word_t e;
      if (hull_q.size() == 0) begin
        report($sformatf("unexpected word %h", got));
        return;
      end
      e = hull_q[0];
      hull_q.delete(0);
      if (got.vertex_x !== e.vertex_x)
        report($sformatf("vertex_x %h, want %h", got.vertex_x, e.vertex_x));
      if (got.vertex_y !== e.vertex_y)
        report($sformatf("vertex_y %h, want %h", got.vertex_y, e.vertex_y));
      if (got.run_end !== e.run_end)
        report($sformatf("run_end %b, want %b", got.run_end, e.run_end));
      if (got.overflowed !== e.overflowed)
        report($sformatf("overflowed %b, want %b", got.overflowed, e.overflowed));
    endtask
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      push = 0;
  logic      full;
  in_word_t  pt_in = '0;
  logic      empty;
  logic      pop = 0;
  out_word_t vtx_out;
  logic      cfg_we = 0;
  logic      cfg_wdata = 0;

  hull_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;     // long receiver hold-off, counted down by the receiver
  bit done_rx = 0;

  always #2 clk = ~clk;

  convex_hull_sorted_output dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .pt_in(pt_in),
    .empty(empty), .pop(pop), .vtx_out(vtx_out), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Receiver: checks the word taken at each edge, then picks pop for the next one.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_vertex(vtx_out);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task send_point(logic [15:0] x, logic [15:0] y, logic last);
    in_word_t w;
    w.point_x = x;
    w.point_y = y;
    w.set_end = last;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    pt_in <= w;
    do @(posedge clk); while (full);
    sb.note_point(w);
  endtask

  // Idle write: all words out, then let the back end settle first.
  task write_mode(bit m);
    push <= 0;
    @(posedge clk);
    while (sb.hull_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 0;
    sb.mode = m;
  endtask

  function logic [15:0] rand_coord(int style, logic [15:0] base);
    case (style)
      0: return 16'($urandom_range(16'hFFFF));
      1: return base + 16'($urandom_range(3));       // tight grid: collinear, duplicates
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  task random_set(int n);
    int style;
    logic [15:0] bx, by;
    style = ($urandom_range(9) < 6) ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
    bx = 16'($urandom_range(16'hFFFC));
    by = 16'($urandom_range(16'hFFFC));
    for (int i = 0; i < n; i++)
      send_point(rand_coord(style, bx), rand_coord(style, by), i == n - 1);
  endtask

  task random_phase(int budget, int big_first);
    int n, r;
    if (big_first > 0) begin
      random_set(big_first);
      budget -= big_first;
    end
    while (budget > 0) begin
      r = $urandom_range(99);
      if (r < 15) n = $urandom_range(2, 1);
      else if (r < 85) n = $urandom_range(12, 3);
      else n = $urandom_range(30, 13);
      random_set(n);
      budget -= n;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    write_mode(0);

    // Directed: single point, extremes, collinear, identical points, a square.
    send_point(16'h0000, 16'h0000, 1);
    send_point(16'hFFFF, 16'hFFFF, 1);
    send_point(16'h0000, 16'hFFFF, 0);
    send_point(16'hFFFF, 16'h0000, 1);
    send_point(16'h0100, 16'h0100, 0);
    send_point(16'h0200, 16'h0200, 0);
    send_point(16'h0300, 16'h0300, 1);
    send_point(16'h1234, 16'h5678, 0);
    send_point(16'h1234, 16'h5678, 0);
    send_point(16'h1234, 16'h5678, 1);
    send_point(16'h0000, 16'h0000, 0);
    send_point(16'hFFFF, 16'h0000, 0);
    send_point(16'h8000, 16'h8000, 0);
    send_point(16'hFFFF, 16'hFFFF, 0);
    send_point(16'h0000, 16'hFFFF, 1);
    write_mode(1);
    send_point(16'h0000, 16'h0000, 0);
    send_point(16'hFFFF, 16'h0000, 0);
    send_point(16'h8000, 16'h8000, 0);
    send_point(16'hFFFF, 16'hFFFF, 0);
    send_point(16'h0000, 16'hFFFF, 1);

    // Sender sparse-ish, receiver mostly stalled; a long hold fills the block first.
    send_idle_pct = 36;
    recv_idle_pct = 80;
    hold_left = 600;
    random_phase(130, 0);
    write_mode(0);

    // Roles swapped; opens with a set whose end marker lands beyond capacity.
    send_idle_pct = 80;
    recv_idle_pct = 36;
    random_phase(130, CAPACITY + 1);
    write_mode(1);

    // Full rate both ways; overflow set with several ignored points.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(130, CAPACITY + 4);
    push <= 0;

    while (sb.hull_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.hull_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
